// ----- src/mixed_query_edge_relax_defines.svh -----
`ifndef MIXED_QUERY_EDGE_RELAX_DEFINES_SVH
`define MIXED_QUERY_EDGE_RELAX_DEFINES_SVH

// same-cycle implication check
`define MQER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check
`define MQER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mqer_pkg.sv -----
package mqer_pkg;

	// wide enough for a VALUE_BITS value plus a 32-bit weight, with a carry
	localparam int EW = 66;

	typedef enum logic [1:0] {
		OP_RELAX,
		OP_LOAD,
		OP_ADVANCE,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		KIND_SHORTEST,
		KIND_BFS,
		KIND_WIDEST,
		KIND_NARROWEST
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_EXEC,
		ST_WRITE,
		ST_ADV_RD,
		ST_ADV_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ld_item;
		logic rd_src;
		logic rd_dst;
		logic cap_src;
		logic cap_dst;
		logic exec;
		logic write;
		logic clr_wr;
		logic adv_rd;
		logic adv_wr;
		logic cnt_clr;
		logic cnt_inc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic item_ok;
		logic cnt_last;
		logic out_free;
	} status_t;

endpackage

// ----- src/mqer_if.sv -----
interface mqer_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [9:0]         src_vertex;
	logic [9:0]         dst_vertex;
	logic signed [31:0] edge_weight;
	logic [2:0]         lane_index;
	logic signed [31:0] load_value;
	logic               load_active;

	modport source (
		output valid, operation, src_vertex, dst_vertex, edge_weight,
		       lane_index, load_value, load_active,
		input  ready
	);
	modport sink (
		input  valid, operation, src_vertex, dst_vertex, edge_weight,
		       lane_index, load_value, load_active,
		output ready
	);
endinterface

interface mqer_out_if;
	logic               valid;
	logic               ready;
	logic               improved;
	logic signed [31:0] read_value;
	logic               read_active;

	modport source (
		output valid, improved, read_value, read_active,
		input  ready
	);
	modport sink (
		input  valid, improved, read_value, read_active,
		output ready
	);
endinterface

// ----- src/mqer_ram.sv -----
module mqer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/mqer_ctrl.sv -----
`include "mixed_query_edge_relax_defines.svh"

module mqer_ctrl import mqer_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_RD1;
			end
			ST_RD1: begin
				if (status.op == OP_ADVANCE) state_d = ST_ADV_RD;
				else if (!status.item_ok)    state_d = ST_DONE;
				else                         state_d = ST_RD2;
			end
			ST_RD2: begin
				state_d = (status.op == OP_RELAX) ? ST_RD3 : ST_EXEC;
			end
			ST_RD3:    state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = (status.op == OP_READ) ? ST_DONE : ST_WRITE;
			end
			ST_WRITE:  state_d = ST_DONE;
			ST_ADV_RD: state_d = ST_ADV_WR;
			ST_ADV_WR: begin
				state_d = status.cnt_last ? ST_DONE : ST_ADV_RD;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = !status.cnt_last;
				cmd.cnt_clr = status.cnt_last;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.ld_item = in_valid;
			end
			ST_RD1:    cmd.rd_src = 1'b1;
			ST_RD2: begin
				cmd.cap_src = 1'b1;
				cmd.rd_dst  = (status.op == OP_RELAX);
			end
			ST_RD3:    cmd.cap_dst = 1'b1;
			ST_EXEC:   cmd.exec = 1'b1;
			ST_WRITE:  cmd.write = 1'b1;
			ST_ADV_RD: cmd.adv_rd = 1'b1;
			ST_ADV_WR: begin
				cmd.adv_wr  = 1'b1;
				cmd.cnt_inc = !status.cnt_last;
				cmd.cnt_clr = status.cnt_last;
			end
			ST_DONE:   cmd.out_load = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	`MQER_ASSERT_NEXT(a_done_holds, clk, arst_n, (state_q == ST_DONE) && !status.out_free, state_q == ST_DONE, "result dropped while output slot busy")
	`MQER_ASSERT_NOW(a_write_in_range, clk, arst_n, cmd.write, status.item_ok, "store written for an out-of-range item")
	`MQER_ASSERT_NEXT(a_adv_ends, clk, arst_n, (state_q == ST_ADV_WR) && status.cnt_last, state_q == ST_DONE, "advance sweep did not finish on the last row")
endmodule

// ----- src/mqer_dp.sv -----
module mqer_dp import mqer_pkg::*; #(
	parameter int LANES      = 8,
	parameter int VERTICES   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	mqer_in_if.sink     in_ch,
	mqer_out_if.source  out_ch,
	input  cmd_t        cmd,
	output status_t     status
);
	localparam int AW = $clog2(VERTICES);
	localparam int VB = VALUE_BITS;
	localparam int RW = LANES * VB;
	localparam logic signed [EW-1:0] VMAX_X = {{(EW-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN_X = ~VMAX_X;
	localparam logic signed [EW-1:0] RMAX_X = {{(EW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [EW-1:0] RMIN_X = ~RMAX_X;

	function automatic logic signed [VB-1:0] clamp_vb(input logic signed [EW-1:0] x);
		if (x > VMAX_X) return VMAX_X[VB-1:0];
		if (x < VMIN_X) return VMIN_X[VB-1:0];
		return x[VB-1:0];
	endfunction

	function automatic logic signed [31:0] clamp_32(input logic signed [EW-1:0] x);
		if (x > RMAX_X) return RMAX_X[31:0];
		if (x < RMIN_X) return RMIN_X[31:0];
		return x[31:0];
	endfunction

	// configuration and item registers
	logic [15:0]        kinds_q;
	op_t                op_q;
	logic [9:0]         src_q, dst_q;
	logic signed [31:0] w_q, lv_q;
	logic [2:0]         lane_q;
	logic               la_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_q <= '0;
		end else if (cfg_we) begin
			kinds_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q   <= op_t'(in_ch.operation);
			src_q  <= in_ch.src_vertex;
			dst_q  <= in_ch.dst_vertex;
			w_q    <= in_ch.edge_weight;
			lane_q <= in_ch.lane_index;
			lv_q   <= in_ch.load_value;
			la_q   <= in_ch.load_active;
		end
	end

	logic src_ok, dst_ok, lane_ok, item_ok;
	assign src_ok  = 32'(src_q) < 32'(VERTICES);
	assign dst_ok  = 32'(dst_q) < 32'(VERTICES);
	assign lane_ok = 32'(lane_q) < 32'(LANES);

	always_comb begin
		case (op_q)
			OP_RELAX: item_ok = src_ok && dst_ok;
			OP_LOAD:  item_ok = src_ok && lane_ok;
			OP_READ:  item_ok = src_ok && lane_ok;
			default:  item_ok = 1'b0;
		endcase
	end

	// row counter for the clearing pass and the advance sweep
	logic [AW-1:0] cnt_q;
	logic          cnt_last;
	assign cnt_last = cnt_q == AW'(VERTICES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// row stores
	logic [AW-1:0]    src_a, dst_a, raddr, waddr;
	logic             re;
	logic             val_we, cur_we, nxt_we;
	logic [RW-1:0]    val_wdata, val_rdata;
	logic [LANES-1:0] cur_wdata, cur_rdata, nxt_wdata, nxt_rdata;

	logic [RW-1:0]    src_val_q, dst_val_q, nv_q;
	logic [LANES-1:0] src_cur_q, dst_nxt_q, nc_q, nm_q;

	assign src_a = AW'(src_q);
	assign dst_a = AW'(dst_q);
	assign re    = cmd.rd_src | cmd.rd_dst | cmd.adv_rd;
	assign raddr = cmd.adv_rd ? cnt_q : (cmd.rd_dst ? dst_a : src_a);
	assign waddr = (cmd.clr_wr | cmd.adv_wr) ? cnt_q :
	               ((op_q == OP_RELAX) ? dst_a : src_a);

	assign val_we    = cmd.clr_wr | (cmd.write & ((op_q == OP_RELAX) | (op_q == OP_LOAD)));
	assign cur_we    = cmd.clr_wr | cmd.adv_wr | (cmd.write & (op_q == OP_LOAD));
	assign nxt_we    = cmd.clr_wr | cmd.adv_wr | (cmd.write & (op_q == OP_RELAX));
	assign val_wdata = cmd.clr_wr ? '0 : nv_q;
	assign cur_wdata = cmd.clr_wr ? '0 : (cmd.adv_wr ? nxt_rdata : nc_q);
	assign nxt_wdata = (cmd.clr_wr | cmd.adv_wr) ? '0 : (dst_nxt_q | nm_q);

	mqer_ram #(.WIDTH(RW), .DEPTH(VERTICES)) u_val (
		.clk(clk), .we(val_we), .waddr(waddr), .wdata(val_wdata),
		.re(re), .raddr(raddr), .rdata(val_rdata)
	);
	mqer_ram #(.WIDTH(LANES), .DEPTH(VERTICES)) u_cur (
		.clk(clk), .we(cur_we), .waddr(waddr), .wdata(cur_wdata),
		.re(re), .raddr(raddr), .rdata(cur_rdata)
	);
	mqer_ram #(.WIDTH(LANES), .DEPTH(VERTICES)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(waddr), .wdata(nxt_wdata),
		.re(re), .raddr(raddr), .rdata(nxt_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_src) begin
			src_val_q <= val_rdata;
			src_cur_q <= cur_rdata;
		end
		if (cmd.cap_dst) begin
			dst_val_q <= val_rdata;
			dst_nxt_q <= nxt_rdata;
		end
	end

	// per-lane update
	logic [RW-1:0]    relax_row, load_row;
	logic [LANES-1:0] take_mask, load_cur, lane_hit;
	logic [31:0]      rdv [LANES];

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic signed [VB-1:0] sv, dv, cand;
		logic signed [EW-1:0] svx, dvx, wx, raw, candx;
		kind_t                kind;
		logic                 take;

		if (j < 8) begin : g_kind
			assign kind = kind_t'(kinds_q[2*j +: 2]);
		end else begin : g_nokind
			assign kind = KIND_SHORTEST;
		end

		assign sv  = src_val_q[j*VB +: VB];
		assign dv  = dst_val_q[j*VB +: VB];
		assign svx = EW'(sv);
		assign dvx = EW'(dv);
		assign wx  = EW'(w_q);

		always_comb begin
			case (kind)
				KIND_SHORTEST: raw = svx + wx;
				KIND_BFS:      raw = svx + EW'(1);
				KIND_WIDEST:   raw = (svx < wx) ? svx : wx;
				default:       raw = (svx > wx) ? svx : wx;
			endcase
		end

		assign cand  = clamp_vb(raw);
		assign candx = EW'(cand);
		assign take  = (kind == KIND_WIDEST) ? (dvx < candx) : (dvx > candx);

		assign take_mask[j]           = src_cur_q[j] & take;
		assign relax_row[j*VB +: VB]  = take_mask[j] ? cand : dv;
		assign lane_hit[j]            = 32'(lane_q) == j;
		assign load_row[j*VB +: VB]   = lane_hit[j] ? clamp_vb(EW'(lv_q)) : sv;
		assign load_cur[j]            = lane_hit[j] ? la_q : src_cur_q[j];
		assign rdv[j]                 = clamp_32(svx);
	end

	logic [31:0] rd_val;
	logic        rd_act;

	always_comb begin
		rd_val = '0;
		rd_act = 1'b0;
		for (int j = 0; j < LANES; j++) begin
			if (lane_hit[j]) begin
				rd_val = rd_val | rdv[j];
				rd_act = rd_act | src_cur_q[j];
			end
		end
	end

	logic [31:0] rv_q;
	logic        ra_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			nv_q <= (op_q == OP_RELAX) ? relax_row : load_row;
			nc_q <= load_cur;
			nm_q <= take_mask;
			rv_q <= rd_val;
			ra_q <= rd_act;
		end
	end

	// output register
	logic               out_valid_q;
	logic               imp_o_q, act_o_q;
	logic signed [31:0] val_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			imp_o_q <= (op_q == OP_RELAX) && item_ok && (|nm_q);
			val_o_q <= ((op_q == OP_READ) && item_ok) ? rv_q : '0;
			act_o_q <= (op_q == OP_READ) && item_ok && ra_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.improved    = imp_o_q;
	assign out_ch.read_value  = val_o_q;
	assign out_ch.read_active = act_o_q;

	assign status.op       = op_q;
	assign status.item_ok  = item_ok;
	assign status.cnt_last = cnt_last;
	assign status.out_free = !out_valid_q || out_ch.ready;
endmodule

// ----- src/mixed_query_edge_relax.sv -----
// Relax reads the source, then the destination row; load and read fetch the source row;
// relax and load then write back. An out-of-range item goes straight to its result. The
// next item is taken once the result has moved to the output register. Throughput is
// set by the single read port of each row store: source and destination rows are
// fetched one after the other; advance walks every vertex row. Reset (arst_n low) clears
// control state; afterwards a clearing pass zeroes every store while no item is taken.
module mixed_query_edge_relax import mqer_pkg::*; #(
	parameter int LANES      = 8,
	parameter int VERTICES   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	mqer_in_if.sink     in_ch,
	mqer_out_if.source  out_ch
);
	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: hold the item, read, compute, write back (relax, load), park the result
	mqer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: row stores, per-lane relaxation and the output register; the output
	// register lets a new transfer in while the previous result still waits
	mqer_dp #(
		.LANES      (LANES),
		.VERTICES   (VERTICES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cmd      (cmd),
		.status   (status)
	);
endmodule
